[sv/radial_wipe_mesh_generator_defines.svh]
// Assertion macros for the radial wipe mesh generator.
`ifndef RADIAL_WIPE_MESH_GENERATOR_DEFINES_SVH
`define RADIAL_WIPE_MESH_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// Check on every clock edge outside reset.
`define RWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check in the cycle after a trigger, outside reset.
`define RWM_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);
`else
`define RWM_ASSERT(lbl, prop, msg)
`define RWM_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

[sv/rwm_pkg.sv]
// Shared types, constants and table functions of the radial wipe mesh generator.
`timescale 1ns / 1ps
package rwm_pkg;

  localparam int SineAddressBitsDefault = 10;
  localparam int QueueDepthDefault      = 2;

  // pi/4 in Q30
  localparam longint unsigned Pi4Q30 = 64'd843314857;

  typedef enum logic [1:0] {
    CfgSizeX   = 2'd0,
    CfgSizeY   = 2'd1,
    CfgOffsetX = 2'd2,
    CfgOffsetY = 2'd3
  } cfg_idx_e;

  typedef logic signed [20:0] coord_t;

  typedef struct packed {
    logic [11:0] size_x;
    logic [11:0] size_y;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
  } cfg_t;

  // One classified request: full rectangle flag, octant and scaled cut offsets.
  typedef struct packed {
    logic        zero;
    logic [2:0]  oct;
    logic [14:0] hx;
    logic [14:0] hy;
  } desc_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
  } corners_t;

  localparam logic [2:0] ZeroVerts = 3'd4;
  localparam logic [2:0] CutVerts  = 3'd7;
  localparam logic [2:0] ZeroTris  = 3'd2;

  function automatic logic [2:0] tri_count(logic [2:0] oct);
    logic [2:0] n;
    unique case (oct)
      3'd0:         n = 3'd5;
      3'd1, 3'd2:   n = 3'd4;
      3'd3, 3'd4:   n = 3'd3;
      3'd5, 3'd6:   n = 3'd2;
      default:      n = 3'd1;
    endcase
    return n;
  endfunction

  // Triangle fan around vertex 0; the fan starts further along as the cut grows.
  function automatic corners_t tri_corners(logic zero, logic [2:0] oct, logic [2:0] num);
    corners_t   c;
    logic [2:0] start;
    logic [2:0] k;
    unique case (oct)
      3'd0:       start = 3'd3;
      3'd1, 3'd2: start = 3'd4;
      3'd3, 3'd4: start = 3'd5;
      default:    start = 3'd6;
    endcase
    k = 3'(start + num - 3'd1);
    c.a = 3'd0;
    if (zero) begin
      c.b = num[0] ? 3'd2 : 3'd1;
      c.c = num[0] ? 3'd3 : 3'd2;
    end else if (oct == 3'd7) begin
      c.b = 3'd6;
      c.c = 3'd2;
    end else if (num == 3'd0) begin
      c.b = 3'd1;
      c.c = 3'd2;
    end else begin
      c.b = k;
      c.c = (k == 3'd6) ? 3'd1 : 3'(k + 3'd1);
    end
    return c;
  endfunction

endpackage

[sv/rwm_if.sv]
// Valid/ready channels for mesh requests and mesh words.
`timescale 1ns / 1ps
interface rwm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cut_angle;

  modport source (output valid, output cut_angle, input ready);
  modport sink   (input valid, input cut_angle, output ready);
endinterface

interface rwm_out_if;
  logic               valid;
  logic               ready;
  logic               is_triangle;
  logic [2:0]         item_number;
  logic signed [20:0] vertex_x;
  logic signed [20:0] vertex_y;
  logic [2:0]         corner_a;
  logic [2:0]         corner_b;
  logic [2:0]         corner_c;
  logic               last;

  modport source (output valid, output is_triangle, output item_number, output vertex_x,
                  output vertex_y, output corner_a, output corner_b, output corner_c,
                  output last, input ready);
  modport sink   (input valid, input is_triangle, input item_number, input vertex_x,
                  input vertex_y, input corner_a, input corner_b, input corner_c,
                  input last, output ready);
endinterface

[sv/radial_wipe_mesh_generator.sv]
// Top level of the radial wipe mesh generator.
`timescale 1ns / 1ps
`include "radial_wipe_mesh_generator_defines.svh"

// Each request word carries a cut angle (65536 units per turn) and produces one
// mesh word stream: the vertices first, then the triangles, with last set on the
// final triangle. Angle zero yields the full rectangle (4 vertices, 2 triangles,
// 6 words); any other angle yields 7 vertices and 1 to 5 triangles (8 to 12
// words). The front end takes one request per cycle while its descriptor queue
// has room; it looks up the cut sine in a registered ROM of
// 2**SINE_ADDRESS_BITS + 1 entries and scales it by the rectangle size into
// registered cut offsets. The sequencer emits one word per cycle while the
// output is ready, so the word count of a request sets the sustained
// rate; meshes follow each other with no gap. Size and offset registers are
// taken from the write port and must only change while the block is idle.
module radial_wipe_mesh_generator
  import rwm_pkg::*;
#(
  parameter int SINE_ADDRESS_BITS = SineAddressBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwm_in_if.sink      in_i,
  rwm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  q_push;
  desc_t q_push_data;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  desc_t q_head;

  // Configuration registers; unused upper data bits drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgSizeX:   cfg_q.size_x   <= cfg_wdata_i[11:0];
        CfgSizeY:   cfg_q.size_y   <= cfg_wdata_i[11:0];
        CfgOffsetX: cfg_q.offset_x <= cfg_wdata_i;
        CfgOffsetY: cfg_q.offset_y <= cfg_wdata_i;
      endcase
    end
  end

  // Classify the angle and scale the cut offset.
  rwm_front #(
    .SineAddressBits (SINE_ADDRESS_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_push_data)
  );

  // Hold a couple of descriptors so the front keeps taking words while a mesh drains.
  rwm_fifo #(
    .Depth (QueueDepthDefault)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_head)
  );

  // Walk the head descriptor one word per cycle while the output is ready.
  rwm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // A new mesh always opens with vertex 0.
  `RWM_ASSERT_NEXT(a_mesh_starts_at_vertex0, out_o.valid && out_o.ready && out_o.last, !out_o.valid || (!out_o.is_triangle && out_o.item_number == 3'd0), "mesh after last does not start at vertex 0")
  // Only a triangle closes a mesh.
  `RWM_ASSERT(a_vertex_never_last, out_o.valid && !out_o.is_triangle |-> !out_o.last, "vertex word flagged last")
  // Every triangle fans out from the center or first corner.
  `RWM_ASSERT(a_fan_from_vertex0, out_o.valid && out_o.is_triangle |-> out_o.corner_a == 3'd0 && out_o.vertex_x == '0, "triangle word malformed")

endmodule

[sv/rwm_front.sv]
// Request front end: octant split, sine lookup and cut offset scaling.
`timescale 1ns / 1ps
module rwm_front
  import rwm_pkg::*;
#(
  parameter int SineAddressBits = SineAddressBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rwm_in_if.sink       in_i,
  input  cfg_t         cfg_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output desc_t        q_data_o
);

  localparam int Shift    = 13 - SineAddressBits;
  localparam int IdxW     = SineAddressBits + 1;
  localparam int RomDepth = (1 << SineAddressBits) + 1;

  typedef logic [14:0] rom_t [RomDepth];

  // Odd Taylor series of sin on the eighth turn, Q30 internally, Q0.15 out.
  function automatic rom_t build_rom();
    rom_t              rom;
    longint unsigned   u;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   sum;
    for (int i = 0; i < RomDepth; i++) begin
      u    = longint'(i) << Shift;
      x    = (u * Pi4Q30) >> 13;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = sum - term;
      rom[i] = 15'((sum + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic            a_valid_q;
  logic            a_zero_q;
  logic [2:0]      a_oct_q;
  logic [14:0]     sine_q;
  logic            b_valid_q;
  logic            b_zero_q;
  logic [2:0]      b_oct_q;
  logic [14:0]     hx_q;
  logic [14:0]     hy_q;
  logic            a_ready;
  logic            b_ready;
  logic            accept;
  logic [12:0]     t;
  logic [13:0]     u;
  logic [IdxW-1:0] rom_idx;
  logic [26:0]     prod_x;
  logic [26:0]     prod_y;

  assign b_ready    = !b_valid_q || !q_full_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_i.ready = a_ready;
  assign accept     = in_i.valid && a_ready;

  // Odd octants run the angle backward from the octant end.
  assign t       = in_i.cut_angle[12:0];
  assign u       = in_i.cut_angle[13] ? 14'(14'd8192 - {1'b0, t}) : {1'b0, t};
  assign rom_idx = u[13 -: IdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= accept;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_zero_q <= (in_i.cut_angle == 16'd0);
      a_oct_q  <= in_i.cut_angle[15:13];
      sine_q   <= SineRom[rom_idx];
    end
  end

  // Round half up: (s * size + 2048) >> 12.
  assign prod_x = 27'(sine_q) * 27'(cfg_i.size_x) + 27'd2048;
  assign prod_y = 27'(sine_q) * 27'(cfg_i.size_y) + 27'd2048;

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_zero_q <= a_zero_q;
      b_oct_q  <= a_oct_q;
      hx_q     <= prod_x[26:12];
      hy_q     <= prod_y[26:12];
    end
  end

  assign q_push_o      = b_valid_q && !q_full_i;
  assign q_data_o.zero = b_zero_q;
  assign q_data_o.oct  = b_oct_q;
  assign q_data_o.hx   = hx_q;
  assign q_data_o.hy   = hy_q;

endmodule

[sv/rwm_fifo.sv]
// Short descriptor queue between front end and sequencer.
`timescale 1ns / 1ps
module rwm_fifo
  import rwm_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output desc_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !do_pop) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (!push_i && do_pop) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[sv/rwm_back.sv]
// Mesh sequencer: walks vertices then triangles of the head request into the output register.
`timescale 1ns / 1ps
module rwm_back
  import rwm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  desc_t     q_data_i,
  output logic      q_pop_o,
  rwm_out_if.source out_o
);

  coord_t     l_q;
  coord_t     t_q;
  coord_t     r_q;
  coord_t     b_q;
  coord_t     cx_q;
  coord_t     cy_q;
  logic [3:0] idx_q;
  logic       out_valid_q;
  logic       is_tri_q;
  logic [2:0] num_q;
  coord_t     vx_q;
  coord_t     vy_q;
  corners_t   corners_q;
  logic       last_q;

  logic       load;
  logic [2:0] nverts;
  logic [2:0] ntris;
  logic       is_vert;
  logic [2:0] vnum;
  logic [2:0] tnum;
  logic       item_last;
  coord_t     hx;
  coord_t     hy;
  coord_t     vx;
  coord_t     vy;
  corners_t   corners;

  // Rectangle geometry in Q.4 pixels; config must only move while idle, which the block does not enforce.
  always_ff @(posedge clk_i) begin
    l_q  <= coord_t'({{1{cfg_i.offset_x[15]}}, cfg_i.offset_x, 4'b0});
    t_q  <= coord_t'({{1{cfg_i.offset_y[15]}}, cfg_i.offset_y, 4'b0});
    r_q  <= coord_t'({{1{cfg_i.offset_x[15]}}, cfg_i.offset_x, 4'b0})
          + coord_t'({5'b0, cfg_i.size_x, 4'b0});
    b_q  <= coord_t'({{1{cfg_i.offset_y[15]}}, cfg_i.offset_y, 4'b0})
          + coord_t'({5'b0, cfg_i.size_y, 4'b0});
    cx_q <= coord_t'({{1{cfg_i.offset_x[15]}}, cfg_i.offset_x, 4'b0})
          + coord_t'({6'b0, cfg_i.size_x, 3'b0});
    cy_q <= coord_t'({{1{cfg_i.offset_y[15]}}, cfg_i.offset_y, 4'b0})
          + coord_t'({6'b0, cfg_i.size_y, 3'b0});
  end

  assign nverts    = q_data_i.zero ? ZeroVerts : CutVerts;
  assign ntris     = q_data_i.zero ? ZeroTris : tri_count(q_data_i.oct);
  assign is_vert   = (idx_q < {1'b0, nverts});
  assign vnum      = idx_q[2:0];
  assign tnum      = 3'(idx_q - {1'b0, nverts});
  assign item_last = !is_vert && (tnum == 3'(ntris - 3'd1));
  assign hx        = coord_t'({6'b0, q_data_i.hx});
  assign hy        = coord_t'({6'b0, q_data_i.hy});
  assign corners   = tri_corners(q_data_i.zero, q_data_i.oct, tnum);

  always_comb begin
    vx = l_q;
    vy = b_q;
    if (q_data_i.zero) begin
      unique case (vnum[1:0])
        2'd0:    begin vx = l_q; vy = t_q; end
        2'd1:    begin vx = r_q; vy = t_q; end
        2'd2:    begin vx = r_q; vy = b_q; end
        default: begin vx = l_q; vy = b_q; end
      endcase
    end else begin
      unique case (vnum)
        3'd0: begin vx = cx_q; vy = cy_q; end
        3'd1: begin vx = l_q;  vy = t_q;  end
        3'd2: begin vx = cx_q; vy = t_q;  end
        3'd3: begin
          vx = (q_data_i.oct == 3'd0) ? cx_q + hy : r_q;
          vy = t_q;
        end
        3'd4: begin
          vx = r_q;
          unique case (q_data_i.oct)
            3'd0:    vy = t_q;
            3'd1:    vy = cy_q - hx;
            3'd2:    vy = cy_q + hx;
            default: vy = b_q;
          endcase
        end
        3'd5: begin
          vy = b_q;
          unique case (q_data_i.oct)
            3'd0, 3'd1, 3'd2: vx = r_q;
            3'd3:             vx = cx_q + hy;
            3'd4:             vx = cx_q - hy;
            default:          vx = l_q;
          endcase
        end
        default: begin
          unique case (q_data_i.oct)
            3'd5:    begin vx = l_q;       vy = cy_q + hx; end
            3'd6:    begin vx = l_q;       vy = cy_q - hx; end
            3'd7:    begin vx = cx_q - hy; vy = t_q;       end
            default: begin vx = l_q;       vy = b_q;       end
          endcase
        end
      endcase
    end
  end

  // Load a word whenever a request is queued and the output register is free or being drained.
  assign load    = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_pop_o = load && item_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= item_last ? '0 : 4'(idx_q + 4'd1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_tri_q  <= !is_vert;
      num_q     <= is_vert ? vnum : tnum;
      vx_q      <= is_vert ? vx : '0;
      vy_q      <= is_vert ? vy : '0;
      corners_q <= is_vert ? '0 : corners;
      last_q    <= item_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_triangle = is_tri_q;
  assign out_o.item_number = num_q;
  assign out_o.vertex_x    = vx_q;
  assign out_o.vertex_y    = vy_q;
  assign out_o.corner_a    = corners_q.a;
  assign out_o.corner_b    = corners_q.b;
  assign out_o.corner_c    = corners_q.c;
  assign out_o.last        = last_q;

endmodule

[tb/radial_wipe_mesh_generator_test.sv]
// Self-checking testbench for the radial wipe mesh generator: directed and random cut angles.
`timescale 1ns / 1ps
module radial_wipe_mesh_generator_test;
  import rwm_pkg::*;

  localparam int SineBits    = SineAddressBitsDefault;
  localparam int ReportLimit = 10;

  // One mesh word as it leaves the block.
  typedef struct packed {
    logic       is_triangle;
    logic [2:0] item_number;
    coord_t     vertex_x;
    coord_t     vertex_y;
    logic [2:0] corner_a;
    logic [2:0] corner_b;
    logic [2:0] corner_c;
    logic       last;
  } mesh_word_t;

  // Triangle fans per octant; a larger cut leaves fewer triangles around the center.
  localparam int FanSize [8] = '{5, 4, 4, 3, 3, 2, 2, 1};
  localparam logic [2:0] FanCorners [8][5][3] = '{
    '{'{0, 1, 2}, '{0, 3, 4}, '{0, 4, 5}, '{0, 5, 6}, '{0, 6, 1}},
    '{'{0, 1, 2}, '{0, 4, 5}, '{0, 5, 6}, '{0, 6, 1}, '{0, 0, 0}},
    '{'{0, 1, 2}, '{0, 4, 5}, '{0, 5, 6}, '{0, 6, 1}, '{0, 0, 0}},
    '{'{0, 1, 2}, '{0, 5, 6}, '{0, 6, 1}, '{0, 0, 0}, '{0, 0, 0}},
    '{'{0, 1, 2}, '{0, 5, 6}, '{0, 6, 1}, '{0, 0, 0}, '{0, 0, 0}},
    '{'{0, 1, 2}, '{0, 6, 1}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
    '{'{0, 1, 2}, '{0, 6, 1}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
    '{'{0, 6, 2}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}
  };

  // Holds a copy of the size/offset registers and the mesh words still due.
  class mesh_scoreboard;
    logic [11:0] size_x;
    logic [11:0] size_y;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    mesh_word_t  mesh_words_due[$];
    int          mismatches;

    function new();
      size_x     = '0;
      size_y     = '0;
      offset_x   = '0;
      offset_y   = '0;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CfgSizeX:   size_x   = value[11:0];
        CfgSizeY:   size_y   = value[11:0];
        CfgOffsetX: offset_x = value;
        CfgOffsetY: offset_y = value;
        default: ;
      endcase
    endfunction

    // Taylor series of sin over one eighth turn, angle in 1/65536 turns, Q30 inside, Q0.15 out.
    function longint unsigned eighth_turn_sine(int unsigned u);
      int unsigned       sh;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint unsigned   sum;
      sh = (SineBits >= 13) ? 0 : 13 - SineBits;
      if (u > 8192) u = 8192;
      u = (u >> sh) << sh;
      x = (longint'(u) * Pi4Q30) >> 13;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 5; k++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      return (sum + 16384) >> 15;
    endfunction

    function void push_vertex(int num, longint x, longint y);
      mesh_word_t w;
      w = '0;
      w.item_number = 3'(num);
      w.vertex_x    = coord_t'(x);
      w.vertex_y    = coord_t'(y);
      mesh_words_due.push_back(w);
    endfunction

    function void push_triangle(int num, logic [2:0] a, logic [2:0] b, logic [2:0] c,
                                logic fin);
      mesh_word_t w;
      w = '0;
      w.is_triangle = 1'b1;
      w.item_number = 3'(num);
      w.corner_a    = a;
      w.corner_b    = b;
      w.corner_c    = c;
      w.last        = fin;
      mesh_words_due.push_back(w);
    endfunction

    // Work out the whole mesh for one accepted cut angle.
    function void note_cut_angle(logic [15:0] angle);
      longint          lft, top, rgt, bot, cx, cy, hx, hy;
      longint          vx [7];
      longint          vy [7];
      longint unsigned s;
      int              oct;
      int unsigned     off;
      lft = longint'($signed(offset_x)) * 16;
      top = longint'($signed(offset_y)) * 16;
      rgt = lft + longint'(size_x) * 16;
      bot = top + longint'(size_y) * 16;
      cx  = lft + longint'(size_x) * 8;
      cy  = top + longint'(size_y) * 8;
      if (angle == 16'd0) begin
        // No cut: plain rectangle, two triangles.
        push_vertex(0, lft, top);
        push_vertex(1, rgt, top);
        push_vertex(2, rgt, bot);
        push_vertex(3, lft, bot);
        push_triangle(0, 3'd0, 3'd1, 3'd2, 1'b0);
        push_triangle(1, 3'd0, 3'd2, 3'd3, 1'b1);
        return;
      end
      oct = int'(angle[15:13]);
      off = int'(angle[12:0]);
      s   = (oct % 2 == 1) ? eighth_turn_sine(8192 - off) : eighth_turn_sine(off);
      hy  = longint'((s * size_y + 2048) >> 12);
      hx  = longint'((s * size_x + 2048) >> 12);
      vx[0] = cx;  vy[0] = cy;
      vx[1] = lft; vy[1] = top;
      vx[2] = cx;  vy[2] = top;
      vx[3] = rgt; vy[3] = top;
      vx[4] = rgt; vy[4] = bot;
      vx[5] = lft; vy[5] = bot;
      vx[6] = lft; vy[6] = bot;
      case (oct)
        0: begin
          vx[3] = cx + hy;
          vx[4] = rgt; vy[4] = top;
          vx[5] = rgt; vy[5] = bot;
        end
        1, 2: begin
          vy[4] = (oct == 1) ? cy - hx : cy + hx;
          vx[5] = rgt;
        end
        3, 4: vx[5] = (oct == 3) ? cx + hy : cx - hy;
        5, 6: vy[6] = (oct == 5) ? cy + hx : cy - hx;
        default: begin
          vx[6] = cx - hy; vy[6] = top;
        end
      endcase
      for (int i = 0; i < 7; i++) push_vertex(i, vx[i], vy[i]);
      for (int i = 0; i < FanSize[oct]; i++) begin
        push_triangle(i, FanCorners[oct][i][0], FanCorners[oct][i][1],
                      FanCorners[oct][i][2], i + 1 == FanSize[oct]);
      end
    endfunction

    function void check_mesh_word(mesh_word_t got);
      mesh_word_t exp;
      string      diffs;
      if (mesh_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: mesh word with nothing due: tri=%0d num=%0d", $realtime,
                   got.is_triangle, got.item_number);
        return;
      end
      exp = mesh_words_due.pop_front();
      if (got === exp) return;
      diffs = "";
      if (got.is_triangle !== exp.is_triangle) diffs = {diffs, " is_triangle"};
      if (got.item_number !== exp.item_number) diffs = {diffs, " item_number"};
      if (got.vertex_x !== exp.vertex_x) diffs = {diffs, " vertex_x"};
      if (got.vertex_y !== exp.vertex_y) diffs = {diffs, " vertex_y"};
      if (got.corner_a !== exp.corner_a) diffs = {diffs, " corner_a"};
      if (got.corner_b !== exp.corner_b) diffs = {diffs, " corner_b"};
      if (got.corner_c !== exp.corner_c) diffs = {diffs, " corner_c"};
      if (got.last !== exp.last) diffs = {diffs, " last"};
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: mesh word mismatch in%s", $realtime, diffs);
        $display("  expected tri=%0d num=%0d x=%0d y=%0d abc=%0d,%0d,%0d last=%0d",
                 exp.is_triangle, exp.item_number, exp.vertex_x, exp.vertex_y,
                 exp.corner_a, exp.corner_b, exp.corner_c, exp.last);
        $display("  actual   tri=%0d num=%0d x=%0d y=%0d abc=%0d,%0d,%0d last=%0d",
                 got.is_triangle, got.item_number, got.vertex_x, got.vertex_y,
                 got.corner_a, got.corner_b, got.corner_c, got.last);
      end
    endfunction

    function int words_due();
      return mesh_words_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  bit          calm;       // no idling on either side
  int          stall_left;

  rwm_in_if  req_if ();
  rwm_out_if word_if ();

  mesh_scoreboard sb;

  radial_wipe_mesh_generator #(
    .SINE_ADDRESS_BITS(SineBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (word_if),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample every accepted mesh word at the rising edge and check it.
  always @(posedge clk_i) begin
    if (rst_ni && word_if.valid && word_if.ready) begin
      sb.check_mesh_word('{is_triangle: word_if.is_triangle,
                           item_number: word_if.item_number,
                           vertex_x:    word_if.vertex_x,
                           vertex_y:    word_if.vertex_y,
                           corner_a:    word_if.corner_a,
                           corner_b:    word_if.corner_b,
                           corner_c:    word_if.corner_c,
                           last:        word_if.last});
    end
  end

  // Receiver: drop ready in random bursts, hold it high once calm.
  initial begin
    stall_left = 0;
    word_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 15);
      if (calm) stall_left = 0;
      if (stall_left > 0) begin
        word_if.ready <= 1'b0;
        stall_left--;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // Present one cut angle, maybe after a gap, and hold it until taken.
  task automatic send_angle(logic [15:0] angle);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid     <= 1'b0;
      req_if.cut_angle <= 16'($urandom);
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cut_angle <= angle;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_cut_angle(angle);
  endtask

  // Drop valid and wait until every mesh word due has come out.
  task automatic drain_meshes();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.words_due() != 0) @(posedge clk_i);
  endtask

  // Write all four registers on an idle block; size words carry junk above bit 11.
  task automatic write_settings(logic [11:0] sx, logic [11:0] sy,
                                logic [15:0] ox, logic [15:0] oy);
    logic [15:0] vals [4];
    cfg_idx_e    idx;
    vals[0] = {4'($urandom), sx};
    vals[1] = {4'($urandom), sy};
    vals[2] = ox;
    vals[3] = oy;
    drain_meshes();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= vals[i];
      sb.set_register(idx, vals[i]);
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly uniform angles, with extra weight on zero and octant edges.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 15));
      2:       return 16'(($urandom_range(1, 8) << 13) - $urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'($urandom_range(1, 16));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 63) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  logic [15:0] directed_angles [] = '{
    16'h0001, 16'h0007, 16'h0008, 16'h1fff, 16'h2000, 16'h2001, 16'h3000,
    16'h4000, 16'h5555, 16'h6000, 16'h7fff, 16'h8000, 16'h9fff, 16'ha000,
    16'haaaa, 16'hc000, 16'hdfff, 16'he000, 16'hfff8, 16'hffff, 16'h0000
  };

  initial begin
    int n_items;
    sb = new();
    calm             = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cut_angle = '0;
    cfg_we           = 1'b0;
    cfg_addr         = CfgSizeX;
    cfg_wdata        = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A degenerate rectangle straight out of reset.
    send_angle(16'h0000);
    send_angle(16'h4321);

    // Directed angles on the largest rectangle at the far corner.
    write_settings(12'd4095, 12'd4095, 16'h7fff, 16'h7fff);
    foreach (directed_angles[i]) send_angle(directed_angles[i]);

    // Random phases; the last one runs with no idling at all.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_settings(12'd4095, 12'd1, 16'h8000, 16'h8000);
        1:       write_settings(12'd0, 12'd4095, 16'h7fff, 16'h8000);
        default: write_settings(pick_size(), pick_size(), pick_offset(), pick_offset());
      endcase
      calm    = (p == 7);
      n_items = (p == 7) ? 70 : 57;
      for (int i = 0; i < n_items; i++) begin
        if (!calm && $urandom_range(0, 59) == 0) drain_meshes();
        send_angle(pick_angle());
      end
    end

    drain_meshes();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.words_due() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
